// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/zzt_pkg.sv =====
// Types and constants for the zigzag row transposer.
// No dependencies.
`timescale 1ns / 1ps

package zzt_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int POS_W   = CNT_W + 1;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
        logic       overflow;
    } out_item_t;

    // Sequencer view handed to the top level.
    typedef struct packed {
        logic [IDX_W-1:0] addr;
        logic             is_final;
    } seq_status_t;

endpackage

// ===== hw/rtl/zzt_seq.sv =====
// Read address sequencer: walks buffer positions in rail fence row order.
// Depends on zzt_pkg.
`timescale 1ns / 1ps

module zzt_seq (
    input  logic                aclk,
    input  logic                start,
    input  zzt_pkg::cnt_t       n,
    input  zzt_pkg::cnt_t       rows,
    input  logic                step,
    output zzt_pkg::seq_status_t status
);
    import zzt_pkg::*;

    cnt_t             n_reg;
    cnt_t             row_reg;
    cnt_t             last_row_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] period_reg;
    logic             mir_reg;

    cnt_t             rows_eff;
    logic             linear;
    logic [POS_W-1:0] mirror_pos;
    logic [POS_W-1:0] pos_step;
    logic [POS_W-1:0] n_ext;
    logic             middle;
    logic             take_mirror;
    logic             pos_ok;
    cnt_t             row_inc;

    // Straight pass is a single row with period one.
    assign rows_eff = (rows == '0) ? cnt_t'(1) : rows;
    assign linear   = (rows_eff == cnt_t'(1)) || (rows_eff >= n);

    assign n_ext       = POS_W'(n_reg);
    assign mirror_pos  = pos_reg + period_reg - {row_reg, 1'b0};
    assign pos_step    = pos_reg + period_reg;
    assign middle      = (row_reg != '0) && (row_reg != last_row_reg);
    assign take_mirror = !mir_reg && middle && (mirror_pos < n_ext);
    assign pos_ok      = pos_step < n_ext;
    assign row_inc     = row_reg + cnt_t'(1);

    assign status.addr     = mir_reg ? mirror_pos[IDX_W-1:0] : pos_reg[IDX_W-1:0];
    assign status.is_final = !take_mirror && !pos_ok && (row_reg == last_row_reg);

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg        <= n;
            row_reg      <= '0;
            pos_reg      <= '0;
            mir_reg      <= 1'b0;
            period_reg   <= linear ? POS_W'(1) : ({rows_eff, 1'b0} - POS_W'(2));
            last_row_reg <= linear ? cnt_t'(0) : (rows_eff - cnt_t'(1));
        end else if (step) begin
            if (take_mirror) begin
                mir_reg <= 1'b1;
            end else begin
                mir_reg <= 1'b0;
                if (pos_ok) begin
                    pos_reg <= pos_step;
                end else begin
                    row_reg <= row_inc;
                    pos_reg <= POS_W'(row_inc);
                end
            end
        end
    end

endmodule

// ===== hw/rtl/zigzag_row_transposer.sv =====
// Zigzag (rail fence) row transposer, top level.
// Depends on zzt_pkg and zzt_seq.
`timescale 1ns / 1ps

//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  input   | s_valid / s_ready         | s_data  : char_in, last_in
//  result  | m_valid / m_ready         | m_data  : char_out, last_out, overflow
//  config  | cfg_valid / cfg_ready     | cfg_data: num_rows (7 bits)
//
//  Load: one byte per cycle into a 64 x 8 buffer RAM (single write port).
//  Emit: after the last-marked transfer, bytes go from the buffer RAM's read
//  register to the output register; no read issues while one is in flight.
//  s_ready is low from the last-marked transfer until the final read issues.
//  Synchronous active-low reset clears control state; buffer is not cleared.
//  A stalled m_ready holds the output register and pauses the read sequencer.

module zigzag_row_transposer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  zzt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output zzt_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);
    import zzt_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Message buffer
    logic [7:0] mem [MAX_LEN];
    logic [7:0] rd_data_reg;

    cnt_t      rows_reg;
    cnt_t      cnt_reg;
    logic      drop_reg;
    logic      ovf_reg;

    // Read in flight toward the output register
    logic      rd_pend_reg;
    logic      rd_last_reg;
    logic      rd_ovf_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic        s_xfer;
    logic        has_room;
    logic        seq_start;
    cnt_t        n_next;
    logic        issue;
    seq_status_t seq_st;

    assign s_ready   = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign s_xfer    = s_valid && s_ready;
    assign has_room  = cnt_reg < cnt_t'(MAX_LEN);
    assign n_next    = has_room ? (cnt_reg + cnt_t'(1)) : cnt_reg;
    assign seq_start = s_xfer && s_data.last_in;

    // A read may issue only if the output register is free when its data lands.
    assign issue = (state_reg == ST_EMIT) && !rd_pend_reg && (!m_valid_reg || m_ready);

    zzt_seq u_seq (
        .aclk   (aclk),
        .start  (seq_start),
        .n      (n_next),
        .rows   (rows_reg),
        .step   (issue),
        .status (seq_st)
    );

    // Buffer RAM: write on load, registered read on issue.
    always_ff @(posedge aclk) begin
        if (s_xfer && has_room) begin
            mem[cnt_reg[IDX_W-1:0]] <= s_data.char_in;
        end
        if (issue) begin
            rd_data_reg <= mem[seq_st.addr];
        end
    end

    // Control FSM with load counters and the read pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            rows_reg    <= cnt_t'(1);
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            rd_ovf_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                rows_reg <= cfg_data;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (s_xfer) begin
                        if (s_data.last_in) begin
                            ovf_reg   <= drop_reg || !has_room;
                            state_reg <= ST_EMIT;
                        end else begin
                            cnt_reg  <= n_next;
                            drop_reg <= drop_reg || !has_room;
                        end
                    end
                end
                ST_EMIT: begin
                    if (issue && seq_st.is_final) begin
                        cnt_reg   <= '0;
                        drop_reg  <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase

            rd_pend_reg <= issue;
            if (issue) begin
                rd_last_reg <= seq_st.is_final;
                rd_ovf_reg  <= ovf_reg;
            end

            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            m_data_reg.char_out <= rd_data_reg;
            m_data_reg.last_out <= rd_last_reg;
            m_data_reg.overflow <= rd_ovf_reg;
        end
    end

endmodule

// ===== hw/rtl/zzt_checker.sv =====
// Port-level checks for the zigzag row transposer, bound to the top level.
// Depends on zzt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zzt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input zzt_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input zzt_pkg::out_item_t m_data
);
    import zzt_pkg::*;

    // Stalled result holds its payload.
    `ASSERT_CLK(a_m_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "m_data changed under stall")

    // A last-marked transfer closes the input.
    `ASSERT_CLK(a_last_closes, aclk, aresetn, (s_valid && s_ready && s_data.last_in) |=> !s_ready, "input open right after last transfer")

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid, "m_valid high after reset")

endmodule

bind zigzag_row_transposer zzt_checker u_zzt_checker (.*);
